/* hdl/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, operation codes and payload types of the text console
// writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;

    localparam int ADDR_W  = $clog2(CELL_COUNT);
    localparam int CNT_W   = $clog2(CELL_COUNT + 1);
    localparam int COL_W   = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
    localparam int ROW_W   = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int SHOWN_W = 11;

    localparam logic [7:0] CH_NEWLINE  = 8'd10;
    localparam logic [7:0] CH_ESCAPE   = 8'd27;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] RESET_COLOR = 8'h07;

    localparam logic [2:0] OP_PUT    = 3'd0;
    localparam logic [2:0] OP_STREAM = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_BEGIN  = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] char_code;
        logic [7:0] attribute;
        logic [6:0] column;
        logic [4:0] row;
    } item_t;

    typedef struct packed {
        logic [6:0]         cursor_col;
        logic [4:0]         cursor_row;
        logic [SHOWN_W-1:0] shown_cursor;
        logic [7:0]         cell_char;
        logic [7:0]         cell_attr;
        logic               read_error;
    } result_t;

endpackage

/* hdl/tcw_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_req_if
// Request channel of the text console writer: valid/ready plus command fields.
// ----------------------------------------------------------------------------
interface tcw_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [6:0] column;
    logic [4:0] row;

    modport source (
        output valid, operation, char_code, attribute, column, row,
        input  ready
    );

    modport sink (
        input  valid, operation, char_code, attribute, column, row,
        output ready
    );
endinterface

/* hdl/tcw_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_rsp_if
// Response channel of the text console writer: valid/ready plus result fields.
// ----------------------------------------------------------------------------
interface tcw_rsp_if;
    logic        valid;
    logic        ready;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] shown_cursor;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        read_error;

    modport source (
        output valid, cursor_col, cursor_row, shown_cursor, cell_char, cell_attr,
               read_error,
        input  ready
    );

    modport sink (
        input  valid, cursor_col, cursor_row, shown_cursor, cell_char, cell_attr,
               read_error,
        output ready
    );
endinterface

/* hdl/tcw_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_engine
// Cell store and sequencer: puts, row blanking, scroll copy, screen fill and
// cell reads, all through one store port pair and one shared address unit.
// ----------------------------------------------------------------------------
module tcw_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  tcw_pkg::item_t   item,
    output logic             res_valid,
    input  logic             res_ready,
    output tcw_pkg::result_t res
);

    localparam logic [3:0] S_FILL   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_PUT    = 4'd2;
    localparam logic [3:0] S_BLANK  = 4'd3;
    localparam logic [3:0] S_SCROLL = 4'd4;
    localparam logic [3:0] S_SHOW   = 4'd5;
    localparam logic [3:0] S_READ   = 4'd6;
    localparam logic [3:0] S_RDATA  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    localparam int ADDR_W = tcw_pkg::ADDR_W;
    localparam int CNT_W  = tcw_pkg::CNT_W;
    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int ROW_W  = tcw_pkg::ROW_W;

    logic [15:0] mem [tcw_pkg::CELL_COUNT];
    logic [15:0] rd_data_reg;

    logic [3:0]                   state_reg, state_next;
    logic [COL_W-1:0]             col_reg, col_next;
    logic [ROW_W-1:0]             row_reg, row_next;
    logic [7:0]                   blank_reg, blank_next;
    logic [7:0]                   stream_reg, stream_next;
    logic                         esc_reg, esc_next;
    logic [tcw_pkg::SHOWN_W-1:0]  shown_reg, shown_next;
    logic [7:0]                   ch_reg, ch_next;
    logic [7:0]                   attr_reg, attr_next;
    logic [ADDR_W-1:0]            addr_reg, addr_next;
    logic [COL_W-1:0]             bcol_reg, bcol_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         pend_reg, pend_next;
    logic                         post_scroll_reg, post_scroll_next;
    logic [15:0]                  fill_data_reg, fill_data_next;
    logic                         fill_rsp_reg, fill_rsp_next;
    logic [7:0]                   cell_char_reg, cell_char_next;
    logic [7:0]                   cell_attr_reg, cell_attr_next;
    logic                         rd_err_reg, rd_err_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // shared address unit: row * columns + column
    logic              sel_item;
    logic [ROW_W-1:0]  lin_row;
    logic [COL_W-1:0]  lin_col;
    logic [ADDR_W-1:0] lin_addr;
    logic [COL_W:0]    ncol;
    logic              in_range;
    logic              scroll_rd;

    always_comb
    begin
        sel_item = (state_reg == S_IDLE) && (item.operation == tcw_pkg::OP_READ);
        lin_row  = sel_item ? item.row[ROW_W-1:0] : row_reg;
        lin_col  = sel_item ? item.column[COL_W-1:0] : col_reg;
        lin_addr = ADDR_W'(int'(lin_row) * tcw_pkg::SCREEN_COLS + int'(lin_col));
    end

    assign ncol      = {1'b0, col_reg} + 1'b1;
    assign in_range  = (int'(item.column) < tcw_pkg::SCREEN_COLS) &&
                       (int'(item.row) < tcw_pkg::SCREEN_ROWS);
    assign scroll_rd = (state_reg == S_SCROLL) &&
                       (cnt_reg != CNT_W'(tcw_pkg::CELL_COUNT));

    assign rd_en   = scroll_rd || (state_reg == S_READ);
    assign rd_addr = (state_reg == S_SCROLL) ? cnt_reg[ADDR_W-1:0] : addr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        blank_next       = blank_reg;
        stream_next      = stream_reg;
        esc_next         = esc_reg;
        shown_next       = shown_reg;
        ch_next          = ch_reg;
        attr_next        = attr_reg;
        addr_next        = addr_reg;
        bcol_next        = bcol_reg;
        cnt_next         = cnt_reg;
        pend_next        = pend_reg;
        post_scroll_next = post_scroll_reg;
        fill_data_next   = fill_data_reg;
        fill_rsp_next    = fill_rsp_reg;
        cell_char_next   = cell_char_reg;
        cell_attr_next   = cell_attr_reg;
        rd_err_next      = rd_err_reg;
        wr_en            = 1'b0;
        wr_addr          = addr_reg;
        wr_data          = {blank_reg, tcw_pkg::CH_SPACE};

        unique case (state_reg)
            S_FILL:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[ADDR_W-1:0];
                wr_data = fill_data_reg;
                if (cnt_reg == CNT_W'(tcw_pkg::CELL_COUNT - 1))
                begin
                    state_next    = fill_rsp_reg ? S_DONE : S_IDLE;
                    fill_rsp_next = 1'b0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (item_valid)
                begin
                    cell_char_next = 8'd0;
                    cell_attr_next = 8'd0;
                    rd_err_next    = 1'b0;
                    ch_next        = item.char_code;
                    addr_next      = lin_addr;
                    unique case (item.operation)
                        tcw_pkg::OP_PUT:
                        begin
                            attr_next  = item.attribute;
                            state_next = S_PUT;
                        end
                        tcw_pkg::OP_STREAM:
                        begin
                            if (esc_reg)
                            begin
                                stream_next = item.char_code;
                                esc_next    = 1'b0;
                                state_next  = S_DONE;
                            end
                            else if (item.char_code == tcw_pkg::CH_ESCAPE)
                            begin
                                esc_next   = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                attr_next  = stream_reg;
                                state_next = S_PUT;
                            end
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            blank_next     = item.attribute;
                            col_next       = '0;
                            row_next       = '0;
                            fill_data_next = {item.attribute, tcw_pkg::CH_SPACE};
                            cnt_next       = '0;
                            fill_rsp_next  = 1'b1;
                            state_next     = S_FILL;
                        end
                        tcw_pkg::OP_BEGIN:
                        begin
                            stream_next = blank_reg;
                            esc_next    = 1'b0;
                            state_next  = S_DONE;
                        end
                        tcw_pkg::OP_READ:
                        begin
                            if (in_range)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                rd_err_next = 1'b1;
                                state_next  = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_PUT:
            begin
                if (ch_reg != tcw_pkg::CH_NEWLINE)
                begin
                    wr_en   = 1'b1;
                    wr_data = {attr_reg, ch_reg};
                end
                if (ch_reg == tcw_pkg::CH_NEWLINE)
                begin
                    // blank from the cursor to the row end
                    bcol_next        = col_reg;
                    post_scroll_next = 1'b0;
                    state_next       = S_BLANK;
                end
                else if (ncol == (COL_W + 1)'(tcw_pkg::SCREEN_COLS))
                begin
                    col_next = '0;
                    if (row_reg == ROW_W'(tcw_pkg::SCREEN_ROWS - 1))
                    begin
                        cnt_next   = CNT_W'(tcw_pkg::SCREEN_COLS);
                        pend_next  = 1'b0;
                        state_next = S_SCROLL;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = S_SHOW;
                    end
                end
                else
                begin
                    col_next   = ncol[COL_W-1:0];
                    state_next = S_SHOW;
                end
            end

            S_BLANK:
            begin
                wr_en = 1'b1;
                if (bcol_reg == COL_W'(tcw_pkg::SCREEN_COLS - 1))
                begin
                    col_next = '0;
                    if (post_scroll_reg)
                    begin
                        state_next = S_SHOW;
                    end
                    else if (row_reg == ROW_W'(tcw_pkg::SCREEN_ROWS - 1))
                    begin
                        cnt_next   = CNT_W'(tcw_pkg::SCREEN_COLS);
                        pend_next  = 1'b0;
                        state_next = S_SCROLL;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = S_SHOW;
                    end
                end
                else
                begin
                    bcol_next = bcol_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
            end

            S_SCROLL:
            begin
                // read one row ahead, write the cell read in the previous cycle
                wr_en     = pend_reg;
                wr_addr   = ADDR_W'(cnt_reg - CNT_W'(tcw_pkg::SCREEN_COLS + 1));
                wr_data   = rd_data_reg;
                pend_next = scroll_rd;
                if (scroll_rd)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    bcol_next        = '0;
                    addr_next        = ADDR_W'((tcw_pkg::SCREEN_ROWS - 1) *
                                               tcw_pkg::SCREEN_COLS);
                    post_scroll_next = 1'b1;
                    state_next       = S_BLANK;
                end
            end

            S_SHOW:
            begin
                shown_next = tcw_pkg::SHOWN_W'(lin_addr);
                state_next = S_DONE;
            end

            S_READ:
            begin
                state_next = S_RDATA;
            end

            S_RDATA:
            begin
                cell_char_next = rd_data_reg[7:0];
                cell_attr_next = rd_data_reg[15:8];
                state_next     = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // the store is swept to zero right after reset
            state_reg       <= S_FILL;
            col_reg         <= '0;
            row_reg         <= '0;
            blank_reg       <= tcw_pkg::RESET_COLOR;
            stream_reg      <= tcw_pkg::RESET_COLOR;
            esc_reg         <= 1'b0;
            shown_reg       <= '0;
            ch_reg          <= '0;
            attr_reg        <= '0;
            addr_reg        <= '0;
            bcol_reg        <= '0;
            cnt_reg         <= '0;
            pend_reg        <= 1'b0;
            post_scroll_reg <= 1'b0;
            fill_data_reg   <= '0;
            fill_rsp_reg    <= 1'b0;
            cell_char_reg   <= '0;
            cell_attr_reg   <= '0;
            rd_err_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            blank_reg       <= blank_next;
            stream_reg      <= stream_next;
            esc_reg         <= esc_next;
            shown_reg       <= shown_next;
            ch_reg          <= ch_next;
            attr_reg        <= attr_next;
            addr_reg        <= addr_next;
            bcol_reg        <= bcol_next;
            cnt_reg         <= cnt_next;
            pend_reg        <= pend_next;
            post_scroll_reg <= post_scroll_next;
            fill_data_reg   <= fill_data_next;
            fill_rsp_reg    <= fill_rsp_next;
            cell_char_reg   <= cell_char_next;
            cell_attr_reg   <= cell_attr_next;
            rd_err_reg      <= rd_err_next;
        end
    end

    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);

    always_comb
    begin
        res.cursor_col   = 7'(col_reg);
        res.cursor_row   = 5'(row_reg);
        res.shown_cursor = shown_reg;
        res.cell_char    = cell_char_reg;
        res.cell_attr    = cell_attr_reg;
        res.read_error   = rd_err_reg;
    end

endmodule

/* hdl/text_console_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: cell store, write cursor, clear color and stream mode.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; req.ready is low while it runs. A
// plain put passes the put and show states and an in-range read the read and
// read-data states before done; a stream escape or color byte, begin stream
// or an unknown code goes straight to done. A newline blanks to the row end
// at one cell per cycle. Leaving the bottom row scrolls, copying one cell per
// cycle, then blanking the bottom row. Clear screen fills all 2000 cells at
// one per cycle. After reset the store is cleared by a pass over all cells
// before the first request is taken. The response sits in an output
// register, so a new request is taken while the previous response waits.
module text_console_writer (
    input  logic clk,
    input  logic rst_n,
    tcw_req_if.sink   req,
    tcw_rsp_if.source rsp
);

    tcw_pkg::item_t   item;
    tcw_pkg::result_t res;
    tcw_pkg::result_t rsp_data_reg;
    logic             rsp_valid_reg;
    logic             res_valid;
    logic             res_ready;

    always_comb
    begin
        item.operation = req.operation;
        item.char_code = req.char_code;
        item.attribute = req.attribute;
        item.column    = req.column;
        item.row       = req.row;
    end

    tcw_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (req.valid),
        .item_ready (req.ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.cursor_col   = rsp_data_reg.cursor_col;
    assign rsp.cursor_row   = rsp_data_reg.cursor_row;
    assign rsp.shown_cursor = rsp_data_reg.shown_cursor;
    assign rsp.cell_char    = rsp_data_reg.cell_char;
    assign rsp.cell_attr    = rsp_data_reg.cell_attr;
    assign rsp.read_error   = rsp_data_reg.read_error;

endmodule

/* hdl/tcw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [6:0] cursor_col,
    input logic [4:0] cursor_row,
    input logic [7:0] cell_char,
    input logic [7:0] cell_attr,
    input logic       read_error
);

    // a stalled response stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // one transaction at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (int'(cursor_col) < tcw_pkg::SCREEN_COLS) &&
                      (int'(cursor_row) < tcw_pkg::SCREEN_ROWS))
        else $error("cursor outside the screen");

    a_rd_err: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && read_error |-> (cell_char == 8'd0) && (cell_attr == 8'd0))
        else $error("cell data on a failed read");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .cursor_col (rsp.cursor_col),
    .cursor_row (rsp.cursor_row),
    .cell_char  (rsp.cell_char),
    .cell_attr  (rsp.cell_attr),
    .read_error (rsp.read_error)
);
